[design/xmlp_pkg.sv]
// shared types, constants and helpers for the move line parser
// no dependencies; every other file refers to it by scoped names
package xmlp_pkg;

	// coordinate width and saturation limits
	localparam int CW = 32;
	localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [CW-1:0] MAG_CAP   = {1'b1, {(CW-1){1'b0}}};

	// largest magnitude that can still take digit d without passing the cap
	localparam logic [CW-1:0] DIG_LIMIT [10] = '{
		(MAG_CAP - CW'(0)) / 10, (MAG_CAP - CW'(1)) / 10,
		(MAG_CAP - CW'(2)) / 10, (MAG_CAP - CW'(3)) / 10,
		(MAG_CAP - CW'(4)) / 10, (MAG_CAP - CW'(5)) / 10,
		(MAG_CAP - CW'(6)) / 10, (MAG_CAP - CW'(7)) / 10,
		(MAG_CAP - CW'(8)) / 10, (MAG_CAP - CW'(9)) / 10
	};

	// stream and config widths
	localparam int OUT_W   = 6 * CW;
	localparam int CFG_IW  = 2;

	// config register indexes
	localparam logic [CFG_IW-1:0] REG_START_X = 2'd0;
	localparam logic [CFG_IW-1:0] REG_START_Y = 2'd1;
	localparam logic [CFG_IW-1:0] REG_START_Z = 2'd2;

	// characters
	localparam logic [7:0] CH_X     = 8'd88;
	localparam logic [7:0] CH_SEMI  = 8'd59;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] DIGIT_LO = 8'd47;
	localparam logic [7:0] DIGIT_HI = 8'd58;

	// parse phases
	localparam logic [1:0] PH_LETTER = 2'd0;
	localparam logic [1:0] PH_SIGN   = 2'd1;
	localparam logic [1:0] PH_DIGITS = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ERR  = 2'd1;
	localparam logic [1:0] ST_HALT = 2'd2;

	// one finished token on its way to the output
	typedef struct packed {
		logic [1:0]         status;
		logic [2:0][CW-1:0] move;
	} tok_res_t;

	// signed add that clamps to the coordinate range
	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW-1:0] s;
		s = a + b;
		if (a[CW-1] == b[CW-1] && s[CW-1] != a[CW-1])
			s = a[CW-1] ? COORD_MIN : COORD_MAX;
		return s;
	endfunction

endpackage

[design/xmlp_parser.sv]
// input register and per-character token parser for the move line parser
// depends on xmlp_pkg; hands one tok_res_t per finished token to the next stage
module xmlp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [7:0]          in_char,
	input  logic                in_last,
	output logic                res_valid_s2,
	output xmlp_pkg::tok_res_t  res_s2
);

	logic                       valid_s1;
	logic [7:0]                 char_s1;
	logic                       last_s1;

	logic [1:0]                 phase_q, phase_n;
	logic [1:0]                 axis_q, axis_n;
	logic                       neg_q, neg_n;
	logic [xmlp_pkg::CW-1:0]    accum_q, accum_n;
	logic [2:0][xmlp_pkg::CW-1:0] moves_q, moves_n;
	logic                       bad_q, bad_n;
	logic                       halted_q;

	logic [3:0]                 digit;
	logic [xmlp_pkg::CW-1:0]    value;
	logic                       tok_ok;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	assign digit = 4'(char_s1 - xmlp_pkg::CH_ZERO);

	// value of the field just closed by a semicolon
	always_comb begin
		if (accum_q[xmlp_pkg::CW-1])
			value = neg_q ? xmlp_pkg::COORD_MIN : xmlp_pkg::COORD_MAX;
		else
			value = neg_q ? (~accum_q + 1'b1) : accum_q;
	end

	// next parse state for the current character
	always_comb begin
		phase_n = phase_q;
		axis_n  = axis_q;
		neg_n   = neg_q;
		accum_n = accum_q;
		moves_n = moves_q;
		bad_n   = bad_q;
		if (!halted_q && !bad_q && phase_q != xmlp_pkg::PH_DONE) begin
			if (phase_q == xmlp_pkg::PH_LETTER) begin
				if (char_s1 == xmlp_pkg::CH_X + {6'd0, axis_q})
					phase_n = xmlp_pkg::PH_SIGN;
				else
					bad_n = 1'b1;
			end else if (phase_q == xmlp_pkg::PH_SIGN && char_s1 == xmlp_pkg::CH_MINUS) begin
				phase_n = xmlp_pkg::PH_DIGITS;
				neg_n   = 1'b1;
			end else begin
				phase_n = xmlp_pkg::PH_DIGITS;
				if (char_s1 > xmlp_pkg::DIGIT_LO && char_s1 < xmlp_pkg::DIGIT_HI) begin
					if (accum_q > xmlp_pkg::DIG_LIMIT[digit])
						accum_n = xmlp_pkg::MAG_CAP;
					else
						accum_n = (accum_q << 3) + (accum_q << 1)
							+ {{(xmlp_pkg::CW-4){1'b0}}, digit};
				end else if (char_s1 == xmlp_pkg::CH_SEMI) begin
					case (axis_q)
						2'd0:    moves_n[0] = value;
						2'd1:    moves_n[1] = value;
						default: moves_n[2] = value;
					endcase
					axis_n  = axis_q + 2'd1;
					neg_n   = 1'b0;
					accum_n = '0;
					phase_n = (axis_q == 2'd2) ? xmlp_pkg::PH_DONE : xmlp_pkg::PH_LETTER;
				end else begin
					bad_n = 1'b1;
				end
			end
		end
	end

	assign tok_ok = !bad_n && phase_n == xmlp_pkg::PH_DONE;

	// parse state, cleared at every token end, where a bad token sets the halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= xmlp_pkg::PH_LETTER;
			axis_q   <= 2'd0;
			neg_q    <= 1'b0;
			accum_q  <= '0;
			moves_q  <= '0;
			bad_q    <= 1'b0;
			halted_q <= 1'b0;
		end else if (en && valid_s1) begin
			if (last_s1) begin
				phase_q <= xmlp_pkg::PH_LETTER;
				axis_q  <= 2'd0;
				neg_q   <= 1'b0;
				accum_q <= '0;
				moves_q <= '0;
				bad_q   <= 1'b0;
				if (!halted_q && !tok_ok)
					halted_q <= 1'b1;
			end else begin
				phase_q <= phase_n;
				axis_q  <= axis_n;
				neg_q   <= neg_n;
				accum_q <= accum_n;
				moves_q <= moves_n;
				bad_q   <= bad_n;
			end
		end
	end

	// token result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (en) begin
			res_valid_s2 <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1 && last_s1) begin
			if (halted_q) begin
				res_s2.status <= xmlp_pkg::ST_HALT;
				res_s2.move   <= '0;
			end else if (tok_ok) begin
				res_s2.status <= xmlp_pkg::ST_OK;
				res_s2.move   <= moves_n;
			end else begin
				res_s2.status <= xmlp_pkg::ST_ERR;
				res_s2.move   <= '0;
			end
		end
	end

endmodule

[design/xmlp_offset.sv]
// running offset accumulator for the move line parser
// depends on xmlp_pkg; takes token results from xmlp_parser
module xmlp_offset (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         res_valid_s2,
	input  xmlp_pkg::tok_res_t           res_s2,
	output logic                         res_valid_s3,
	output xmlp_pkg::tok_res_t           res_s3,
	output logic [2:0][xmlp_pkg::CW-1:0] offset_q
);

	// offsets move only on a good token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (en && res_valid_s2 && res_s2.status == xmlp_pkg::ST_OK) begin
			for (int k = 0; k < 3; k++)
				offset_q[k] <= xmlp_pkg::sat_add(offset_q[k], res_s2.move[k]);
		end
	end

	// result stage alongside the updated offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s3 <= 1'b0;
		end else if (en) begin
			res_valid_s3 <= res_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_valid_s2)
			res_s3 <= res_s2;
	end

endmodule

[design/xyz_move_line_parser.sv]
// Takes one character per cycle while not held; every item can follow the last
// in the next cycle. A token's result passes through the input register, parse
// stage, offset stage and output register; the whole pipeline holds while the
// output register waits to be taken. Config writes are always ready.
// top level of the move line parser; depends on xmlp_pkg, xmlp_parser and xmlp_offset
module xyz_move_line_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	// input stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // char_code
	input  logic                         s_axis_tlast,  // token_end
	// result stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// pos_x, pos_y, pos_z, move_x, move_y, move_z
	output logic [xmlp_pkg::OUT_W-1:0]   m_axis_tdata,
	output logic [1:0]                   m_axis_tuser,  // status
	// config write channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [xmlp_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [xmlp_pkg::CW-1:0]      cfg_data
);

	logic                          en;
	logic                          res_valid_s2, res_valid_s3;
	xmlp_pkg::tok_res_t            res_s2, res_s3;
	logic [2:0][xmlp_pkg::CW-1:0]  offset_q;
	logic [2:0][xmlp_pkg::CW-1:0]  start_q;
	logic [2:0][xmlp_pkg::CW-1:0]  pos_q;
	logic [2:0][xmlp_pkg::CW-1:0]  move_q;
	logic [1:0]                    status_q;
	logic                          out_valid_q;

	// pipeline advances whenever the output register can take a result
	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	// start coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				xmlp_pkg::REG_START_X: start_q[0] <= cfg_data;
				xmlp_pkg::REG_START_Y: start_q[1] <= cfg_data;
				xmlp_pkg::REG_START_Z: start_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	xmlp_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (s_axis_tvalid),
		.in_char      (s_axis_tdata),
		.in_last      (s_axis_tlast),
		.res_valid_s2 (res_valid_s2),
		.res_s2       (res_s2)
	);

	xmlp_offset u_offset (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.res_valid_s2 (res_valid_s2),
		.res_s2       (res_s2),
		.res_valid_s3 (res_valid_s3),
		.res_s3       (res_s3),
		.offset_q     (offset_q)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= res_valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && res_valid_s3) begin
			for (int k = 0; k < 3; k++)
				pos_q[k] <= xmlp_pkg::sat_add(start_q[k], offset_q[k]);
			move_q   <= res_s3.move;
			status_q <= res_s3.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {move_q[2], move_q[1], move_q[0], pos_q[2], pos_q[1], pos_q[0]};
	assign m_axis_tuser  = status_q;

endmodule

[tb/tb_xyz_move_line_parser.sv]
// testbench for xyz_move_line_parser: streams command tokens one character per
// transaction, predicts every token result and checks it field by field
// depends on xmlp_pkg and the parser design files
module tb_xyz_move_line_parser;

	// coordinate width used throughout the predictor
	localparam int CW = xmlp_pkg::CW;

	typedef logic [7:0] char_q_t [$];

	// one expected token result, fields in stream order from the lowest bit up
	typedef struct packed {
		logic [1:0]         status;
		logic [2:0][CW-1:0] move;
		logic [2:0][CW-1:0] pos;
	} token_report_t;

	typedef enum {BAD_LETTER, BAD_VALUE_CHAR, EARLY_END} fault_kind_t;

	localparam longint MAG_LIMIT  = longint'(1) << (CW - 1);
	localparam int     PIPE_SLACK = 8;

	logic                        clk           = 1'b0;
	logic                        arst_n        = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [7:0]                  s_axis_tdata  = '0;  // char_code
	logic                        s_axis_tlast  = 1'b0; // token_end
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	// pos_x, pos_y, pos_z, move_x, move_y, move_z
	logic [xmlp_pkg::OUT_W-1:0]  m_axis_tdata;
	logic [1:0]                  m_axis_tuser;  // status
	logic                        cfg_valid     = 1'b0;
	logic                        cfg_ready;
	logic [xmlp_pkg::CFG_IW-1:0] cfg_index     = '0;
	logic [CW-1:0]               cfg_data      = '0;

	// parser state as the predictor sees it
	logic [1:0]    scan_phase     = xmlp_pkg::PH_LETTER;
	int            scan_axis      = 0;
	bit            scan_neg       = 1'b0;
	longint        scan_mag       = 0;
	longint        scan_moves [3] = '{0, 0, 0};
	bit            token_bad      = 1'b0;
	bit            parser_halted  = 1'b0;
	longint        offset_sum [3] = '{0, 0, 0};
	longint        start_coord [3] = '{0, 0, 0};

	token_report_t expected_reports [$];
	int            mismatch_count = 0;
	int            send_idle_pct  = 0;
	int            recv_idle_pct  = 0;
	string         field_names [6] = '{"pos_x", "pos_y", "pos_z", "move_x", "move_y", "move_z"};

	xyz_move_line_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic longint clamp_coord(input longint v);
		if (v > MAG_LIMIT - 1)
			return MAG_LIMIT - 1;
		if (v < -MAG_LIMIT)
			return -MAG_LIMIT;
		return v;
	endfunction

	function automatic void report_mismatch(input string field, input logic [CW-1:0] want,
			input logic [CW-1:0] got);
		mismatch_count++;
		$display("%0t: %s expected %0d, got %0d", $time, field, $signed(want), $signed(got));
	endfunction

	function automatic void clear_scan();
		scan_phase = xmlp_pkg::PH_LETTER;
		scan_axis  = 0;
		scan_neg   = 1'b0;
		scan_mag   = 0;
		scan_moves = '{0, 0, 0};
		token_bad  = 1'b0;
	endfunction

	// advance the parser by one accepted character, queue a result on token end
	function automatic void track_char(input logic [7:0] c, input logic last);
		longint        dig;
		longint        val;
		token_report_t rep;
		if (!parser_halted && !token_bad && scan_phase != xmlp_pkg::PH_DONE) begin
			if (scan_phase == xmlp_pkg::PH_LETTER) begin
				if (c == 8'(xmlp_pkg::CH_X + scan_axis))
					scan_phase = xmlp_pkg::PH_SIGN;
				else
					token_bad = 1'b1;
			end else if (scan_phase == xmlp_pkg::PH_SIGN && c == xmlp_pkg::CH_MINUS) begin
				scan_phase = xmlp_pkg::PH_DIGITS;
				scan_neg   = 1'b1;
			end else begin
				scan_phase = xmlp_pkg::PH_DIGITS;
				if (c > xmlp_pkg::DIGIT_LO && c < xmlp_pkg::DIGIT_HI) begin
					// magnitude sticks at the cap once it would pass it
					dig = longint'(c - xmlp_pkg::CH_ZERO);
					if (scan_mag > (MAG_LIMIT - dig) / 10)
						scan_mag = MAG_LIMIT;
					else
						scan_mag = scan_mag * 10 + dig;
				end else if (c == xmlp_pkg::CH_SEMI) begin
					if (scan_neg)
						val = (scan_mag >= MAG_LIMIT) ? -MAG_LIMIT : -scan_mag;
					else
						val = (scan_mag >= MAG_LIMIT) ? MAG_LIMIT - 1 : scan_mag;
					scan_moves[scan_axis] = val;
					scan_axis++;
					scan_neg   = 1'b0;
					scan_mag   = 0;
					scan_phase = (scan_axis >= 3) ? xmlp_pkg::PH_DONE : xmlp_pkg::PH_LETTER;
				end else begin
					token_bad = 1'b1;
				end
			end
		end
		if (last) begin
			rep = '0;
			if (parser_halted) begin
				rep.status = xmlp_pkg::ST_HALT;
			end else if (!token_bad && scan_phase == xmlp_pkg::PH_DONE) begin
				rep.status = xmlp_pkg::ST_OK;
				for (int k = 0; k < 3; k++) begin
					rep.move[k]   = CW'(scan_moves[k]);
					offset_sum[k] = clamp_coord(offset_sum[k] + scan_moves[k]);
				end
			end else begin
				rep.status    = xmlp_pkg::ST_ERR;
				parser_halted = 1'b1;
			end
			clear_scan();
			for (int k = 0; k < 3; k++)
				rep.pos[k] = CW'(clamp_coord(start_coord[k] + offset_sum[k]));
			expected_reports.push_back(rep);
		end
	endfunction

	// one character transaction, with random idle cycles ahead of it
	task automatic send_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		track_char(c, last);
	endtask

	task automatic send_chars(input char_q_t q);
		foreach (q[i])
			send_char(q[i], i == q.size() - 1);
	endtask

	// stop sending until every pending result is out and the pipeline is empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_reports.size() != 0)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic write_start(input logic [xmlp_pkg::CFG_IW-1:0] idx,
			input logic [CW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		start_coord[idx] = longint'(signed'(data));
		@(posedge clk);
	endtask

	task automatic set_starts(input logic [CW-1:0] x, input logic [CW-1:0] y,
			input logic [CW-1:0] z);
		write_start(xmlp_pkg::REG_START_X, x);
		write_start(xmlp_pkg::REG_START_Y, y);
		write_start(xmlp_pkg::REG_START_Z, z);
	endtask

	function automatic char_q_t text_chars(input string s);
		char_q_t q;
		for (int i = 0; i < s.len(); i++)
			q.push_back(s[i]);
		return q;
	endfunction

	// optional minus, then mostly short digit strings, sometimes long enough to saturate
	function automatic void push_value(ref char_q_t q);
		int pick;
		int n;
		if ($urandom_range(99) < 35)
			q.push_back(xmlp_pkg::CH_MINUS);
		pick = $urandom_range(99);
		if (pick < 60)
			n = $urandom_range(3);
		else if (pick < 90)
			n = $urandom_range(9, 4);
		else
			n = $urandom_range(12, 10);
		repeat (n) q.push_back(8'(xmlp_pkg::CH_ZERO + $urandom_range(9)));
	endfunction

	// well-formed token with random values and up to max_junk ignored trailing bytes
	function automatic void make_token(ref char_q_t q, input int max_junk);
		q = {};
		for (int a = 0; a < 3; a++) begin
			q.push_back(8'(xmlp_pkg::CH_X + a));
			push_value(q);
			q.push_back(xmlp_pkg::CH_SEMI);
		end
		repeat ($urandom_range(max_junk)) q.push_back(8'($urandom_range(255)));
	endfunction

	// empty values, bare minus, leading zeros, junk after the last separator
	task automatic test_value_forms();
		char_q_t q;
		send_chars(text_chars("X;Y;Z;"));
		q = text_chars("X-;Y-0;Z007;");
		q.push_back(8'h00);
		q.push_back(8'hFF);
		q.push_back(xmlp_pkg::CH_SEMI);
		send_chars(q);
		send_chars(text_chars("X123;Y-45;Z6;"));
	endtask

	// long values, offsets and positions pinned at both ends of the range
	task automatic test_saturation();
		set_starts(xmlp_pkg::COORD_MAX, xmlp_pkg::COORD_MIN, '0);
		send_chars(text_chars("X2147483647;Y-2147483648;Z2147483648;"));
		send_chars(text_chars("X99999999999;Y-99999999999;Z-2147483649;"));
		send_chars(text_chars("X-99999999999;Y99999999999;Z1;"));
	endtask

	task automatic test_random_tokens(input int n_chars);
		char_q_t q;
		int      sent;
		sent = 0;
		while (sent < n_chars) begin
			make_token(q, 3);
			send_chars(q);
			sent += q.size();
		end
	endtask

	// an error halts the parser until reset, so this runs last
	task automatic test_halt_after_error();
		char_q_t     q;
		fault_kind_t kind;
		logic [7:0]  c;
		int          pos;
		make_token(q, 0);
		kind = fault_kind_t'($urandom_range(2));
		case (kind)
			BAD_LETTER: begin
				do c = 8'($urandom_range(255)); while (c == xmlp_pkg::CH_X);
				q[0] = c;
			end
			BAD_VALUE_CHAR: begin
				do c = 8'($urandom_range(255));
				while ((c > xmlp_pkg::DIGIT_LO && c < xmlp_pkg::DIGIT_HI) ||
					c == xmlp_pkg::CH_SEMI || c == xmlp_pkg::CH_MINUS ||
					(c >= xmlp_pkg::CH_X && c <= 8'(xmlp_pkg::CH_X + 2)));
				pos = $urandom_range(q.size() - 1, 1);
				q.insert(pos, c);
			end
			default: begin
				// cut somewhere before the third separator
				pos = $urandom_range(q.size() - 1, 1);
				q = q[0:pos-1];
			end
		endcase
		send_chars(q);
		// halted: everything is ignored, each token end reports the halt
		repeat (8) begin
			if ($urandom_range(1)) begin
				make_token(q, 2);
			end else begin
				q = {};
				repeat ($urandom_range(8, 1)) q.push_back(8'($urandom_range(255)));
			end
			send_chars(q);
		end
	endtask

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin : check_results
		token_report_t              rep;
		logic [xmlp_pkg::OUT_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch("unexpected result status", '0, CW'(m_axis_tuser));
			end else begin
				rep  = expected_reports.pop_front();
				want = {rep.move, rep.pos};
				for (int k = 0; k < 6; k++)
					if (m_axis_tdata[k*CW +: CW] !== want[k*CW +: CW])
						report_mismatch(field_names[k], want[k*CW +: CW],
							m_axis_tdata[k*CW +: CW]);
				if (m_axis_tuser !== rep.status)
					report_mismatch("status", CW'(rep.status), CW'(m_axis_tuser));
			end
		end
	end

	// test sequence
	initial begin : run_tests
		send_idle_pct = 22;
		recv_idle_pct = 73;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_value_forms();
		settle();
		test_saturation();
		settle();
		set_starts($urandom, $urandom, $urandom);
		test_random_tokens(180);
		settle();

		send_idle_pct = 73;
		recv_idle_pct = 22;
		set_starts(xmlp_pkg::COORD_MIN, xmlp_pkg::COORD_MAX, $urandom);
		test_random_tokens(180);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_starts($urandom, '0, xmlp_pkg::COORD_MAX);
		test_random_tokens(180);
		test_halt_after_error();

		// drain and finish
		s_axis_tvalid <= 1'b0;
		for (int n = 0; n < 20000 && expected_reports.size() != 0; n++)
			@(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
		if (expected_reports.size() != 0) begin
			mismatch_count++;
			$display("%0t: %0d results never arrived", $time, expected_reports.size());
		end
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// hard stop if the run hangs
	initial begin : watchdog
		#(8 * 200000);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
design/xmlp_pkg.sv
design/xmlp_parser.sv
design/xmlp_offset.sv
design/xyz_move_line_parser.sv
tb/tb_xyz_move_line_parser.sv
